// ===== hdl/abtk_pkg.sv =====
// Shared types, constants and the rank comparison of the age-bucketed top-k ranker.
// Used by the controller, the datapath and the top level; depends on nothing else.
package abtk_pkg;

    localparam int NAME_W  = 64;
    localparam int AGE_W   = 8;
    localparam int WORTH_W = 21;
    localparam int CNT_W   = 7;
    localparam int MAX_OUT = 64;
    localparam int BEST_AW = 6;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [NAME_W-1:0]         name;
        logic [AGE_W-1:0]          age;
        logic signed [WORTH_W-1:0] worth;
    } rec_t;

    typedef struct packed {
        logic [NAME_W-1:0]         name;
        logic signed [WORTH_W-1:0] worth;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_APPEND,
        OP_WSCAN_FIRST,
        OP_WORST_STEP,
        OP_REPLACE,
        OP_NEXT_AGE,
        OP_SCAN_FIRST,
        OP_CAND,
        OP_CMP,
        OP_PLACE,
        OP_OUT_FIRST,
        OP_OUT_NONE,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic ins_ok;
        logic q_empty;
        logic fill_zero;
        logic full;
        logic worst_last;
        logic bcount_zero;
        logic ahead;
        logic p_one;
        logic slot_last;
        logic age_last;
        logic out_free;
        logic out_last;
    } dp_sts_t;

    // True when a ranks strictly ahead of b.
    function automatic logic ahead(input rec_t a, input rec_t b);
        logic r;
        if (a.worth != b.worth)
        begin
            r = (a.worth > b.worth);
        end
        else if (a.age != b.age)
        begin
            r = (a.age < b.age);
        end
        else
        begin
            r = (a.name < b.name);
        end
        return r;
    endfunction

endpackage

// ===== hdl/abtk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; used by the datapath for every store.
module abtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/abtk_ctrl.sv =====
// Controller state machine of the ranker: sequences inserts, query scans and result output.
// Depends on abtk_pkg; drives the datapath by command and reads back its status.
module abtk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    output abtk_pkg::dp_cmd_t ctl,
    input  abtk_pkg::dp_sts_t sts
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_I_FRD  = 12'b0000_0000_0010,
        S_I_FCHK = 12'b0000_0000_0100,
        S_I_SCAN = 12'b0000_0000_1000,
        S_I_REPL = 12'b0000_0001_0000,
        S_Q_FRD  = 12'b0000_0010_0000,
        S_Q_FCHK = 12'b0000_0100_0000,
        S_Q_SRD  = 12'b0000_1000_0000,
        S_Q_CMP  = 12'b0001_0000_0000,
        S_Q_PLC  = 12'b0010_0000_0000,
        S_O_FRST = 12'b0100_0000_0000,
        S_O_LOAD = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = abtk_pkg::OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.op = abtk_pkg::OP_LOAD;
                    if (sts.is_query)
                    begin
                        state_next = sts.q_empty ? S_O_FRST : S_Q_FRD;
                    end
                    else
                    begin
                        state_next = sts.ins_ok ? S_I_FRD : S_IDLE;
                    end
                end
            end
            S_I_FRD:
            begin
                state_next = S_I_FCHK;
            end
            S_I_FCHK:
            begin
                if (sts.full)
                begin
                    ctl.op     = abtk_pkg::OP_WSCAN_FIRST;
                    state_next = S_I_SCAN;
                end
                else
                begin
                    ctl.op     = abtk_pkg::OP_APPEND;
                    state_next = S_IDLE;
                end
            end
            S_I_SCAN:
            begin
                ctl.op = abtk_pkg::OP_WORST_STEP;
                if (sts.worst_last)
                begin
                    state_next = S_I_REPL;
                end
            end
            S_I_REPL:
            begin
                ctl.op     = abtk_pkg::OP_REPLACE;
                state_next = S_IDLE;
            end
            S_Q_FRD:
            begin
                state_next = S_Q_FCHK;
            end
            S_Q_FCHK:
            begin
                if (sts.fill_zero)
                begin
                    ctl.op     = abtk_pkg::OP_NEXT_AGE;
                    state_next = sts.age_last ? S_O_FRST : S_Q_FRD;
                end
                else
                begin
                    ctl.op     = abtk_pkg::OP_SCAN_FIRST;
                    state_next = S_Q_SRD;
                end
            end
            S_Q_SRD:
            begin
                ctl.op     = abtk_pkg::OP_CAND;
                state_next = sts.bcount_zero ? S_Q_PLC : S_Q_CMP;
            end
            S_Q_CMP:
            begin
                ctl.op = abtk_pkg::OP_CMP;
                if (!sts.ahead || sts.p_one)
                begin
                    state_next = S_Q_PLC;
                end
            end
            S_Q_PLC:
            begin
                ctl.op = abtk_pkg::OP_PLACE;
                if (!sts.slot_last)
                begin
                    state_next = S_Q_SRD;
                end
                else
                begin
                    state_next = sts.age_last ? S_O_FRST : S_Q_FRD;
                end
            end
            S_O_FRST:
            begin
                if (!sts.bcount_zero)
                begin
                    ctl.op     = abtk_pkg::OP_OUT_FIRST;
                    state_next = S_O_LOAD;
                end
                else if (sts.out_free)
                begin
                    ctl.op     = abtk_pkg::OP_OUT_NONE;
                    state_next = S_IDLE;
                end
            end
            S_O_LOAD:
            begin
                if (sts.out_free)
                begin
                    ctl.op = abtk_pkg::OP_OUT_LOAD;
                    if (sts.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/abtk_dp.sv =====
// Datapath of the ranker: bucket store, fill counts, ranked selection list and output register.
// Depends on abtk_pkg and abtk_ram; carries out the commands of abtk_ctrl.
module abtk_dp #(
    parameter int BUCKET_DEPTH = 64,
    parameter int AGE_BUCKETS  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  abtk_pkg::dp_cmd_t                   ctl,
    output abtk_pkg::dp_sts_t                   sts,
    input  logic                                cmd,
    input  logic [abtk_pkg::NAME_W-1:0]         person_name,
    input  logic [abtk_pkg::AGE_W-1:0]          person_age,
    input  logic signed [abtk_pkg::WORTH_W-1:0] person_worth,
    input  logic [abtk_pkg::CNT_W-1:0]          want_count,
    input  logic [abtk_pkg::AGE_W-1:0]          age_low,
    input  logic [abtk_pkg::AGE_W-1:0]          age_high,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic                                found,
    output logic [abtk_pkg::NAME_W-1:0]         out_name,
    output logic [abtk_pkg::AGE_W-1:0]          out_age,
    output logic signed [abtk_pkg::WORTH_W-1:0] out_worth,
    output logic                                last
);

    localparam int AW = $clog2(AGE_BUCKETS);
    localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int SD = 1 << (AW + SW);
    localparam int GW = abtk_pkg::AGE_W;
    localparam int CW = abtk_pkg::CNT_W;
    localparam int BW = abtk_pkg::BEST_AW;

    abtk_pkg::entry_t rec_reg, rec_next;
    abtk_pkg::rec_t   worst_reg, worst_next;
    abtk_pkg::rec_t   cand_reg, cand_next;
    abtk_pkg::rec_t   in_rec, s_rec, brd;
    abtk_pkg::entry_t srd, s_wdata;
    abtk_pkg::rec_t   b_wdata;

    logic [GW-1:0] age_reg, age_next, hi_reg, hi_next, hi_clip;
    logic [CW-1:0] cnt_reg, cnt_next, p_reg, p_next, bcnt_reg, bcnt_next;
    logic [FW-1:0] fill_reg, fill_next, fill_rd, fill_eff, f_wdata;
    logic [SW-1:0] slot_reg, slot_next, wslot_reg, wslot_next, s_slot;
    logic [BW-1:0] brd_reg, brd_next, b_waddr;
    logic [AGE_BUCKETS-1:0] fvalid_reg, fvalid_next;
    logic          s_we, f_we, b_we;

    logic                                found_reg, found_next, last_reg, last_next;
    logic                                rv_reg, rv_next;
    logic [abtk_pkg::NAME_W-1:0]         oname_reg, oname_next;
    logic [GW-1:0]                       oage_reg, oage_next;
    logic signed [abtk_pkg::WORTH_W-1:0] owrth_reg, owrth_next;

    abtk_ram #(.WIDTH($bits(abtk_pkg::entry_t)), .DEPTH(SD)) u_store (
        .clk   (clk),
        .we    (s_we),
        .waddr ({age_reg[AW-1:0], s_slot}),
        .wdata (s_wdata),
        .raddr ({age_next[AW-1:0], slot_next}),
        .rdata (srd)
    );

    abtk_ram #(.WIDTH(FW), .DEPTH(1 << AW)) u_fill (
        .clk   (clk),
        .we    (f_we),
        .waddr (age_reg[AW-1:0]),
        .wdata (f_wdata),
        .raddr (age_next[AW-1:0]),
        .rdata (fill_rd)
    );

    abtk_ram #(.WIDTH($bits(abtk_pkg::rec_t)), .DEPTH(abtk_pkg::MAX_OUT)) u_best (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (brd_next),
        .rdata (brd)
    );

    // A bucket never written reads as empty.
    assign fill_eff = fvalid_reg[age_reg[AW-1:0]] ? fill_rd : '0;
    assign in_rec   = '{name: rec_reg.name, age: age_reg, worth: rec_reg.worth};
    assign s_rec    = '{name: srd.name, age: age_reg, worth: srd.worth};
    assign hi_clip  = ({1'b0, age_high} >= (GW + 1)'(AGE_BUCKETS))
                      ? GW'(AGE_BUCKETS - 1) : age_high;

    always_comb
    begin
        sts.is_query    = (cmd == abtk_pkg::CMD_QUERY);
        sts.ins_ok      = ({1'b0, person_age} < (GW + 1)'(AGE_BUCKETS));
        sts.q_empty     = (want_count == '0) || (age_low > hi_clip);
        sts.fill_zero   = (fill_eff == '0);
        sts.full        = (fill_eff == FW'(BUCKET_DEPTH));
        sts.worst_last  = (slot_reg == SW'(BUCKET_DEPTH - 1));
        sts.bcount_zero = (bcnt_reg == '0);
        sts.ahead       = abtk_pkg::ahead(cand_reg, brd);
        sts.p_one       = (p_reg == CW'(1));
        sts.slot_last   = ((FW'(slot_reg) + FW'(1)) == fill_reg);
        sts.age_last    = (age_reg == hi_reg);
        sts.out_free    = !rv_reg || rsp_ready;
        sts.out_last    = ((CW'(brd_reg) + CW'(1)) == bcnt_reg);
    end

    always_comb
    begin
        rec_next    = rec_reg;
        worst_next  = worst_reg;
        cand_next   = cand_reg;
        age_next    = age_reg;
        hi_next     = hi_reg;
        cnt_next    = cnt_reg;
        p_next      = p_reg;
        bcnt_next   = bcnt_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        wslot_next  = wslot_reg;
        brd_next    = brd_reg;
        fvalid_next = fvalid_reg;
        found_next  = found_reg;
        last_next   = last_reg;
        oname_next  = oname_reg;
        oage_next   = oage_reg;
        owrth_next  = owrth_reg;
        rv_next     = rv_reg && !rsp_ready;
        s_we        = 1'b0;
        s_slot      = slot_reg;
        s_wdata     = rec_reg;
        f_we        = 1'b0;
        f_wdata     = fill_eff + FW'(1);
        b_we        = 1'b0;
        b_waddr     = p_reg[BW-1:0];
        b_wdata     = cand_reg;
        unique case (ctl.op)
            abtk_pkg::OP_NONE:
            begin
            end
            abtk_pkg::OP_LOAD:
            begin
                rec_next  = '{name: person_name, worth: person_worth};
                age_next  = (cmd == abtk_pkg::CMD_QUERY) ? age_low : person_age;
                hi_next   = hi_clip;
                cnt_next  = (want_count > CW'(abtk_pkg::MAX_OUT))
                            ? CW'(abtk_pkg::MAX_OUT) : want_count;
                bcnt_next = '0;
            end
            abtk_pkg::OP_APPEND:
            begin
                s_we        = 1'b1;
                s_slot      = fill_eff[SW-1:0];
                f_we        = 1'b1;
                fvalid_next[age_reg[AW-1:0]] = 1'b1;
            end
            abtk_pkg::OP_WSCAN_FIRST:
            begin
                slot_next = '0;
            end
            abtk_pkg::OP_WORST_STEP:
            begin
                if (slot_reg == '0 || abtk_pkg::ahead(worst_reg, s_rec))
                begin
                    worst_next = s_rec;
                    wslot_next = slot_reg;
                end
                slot_next = slot_reg + SW'(1);
            end
            abtk_pkg::OP_REPLACE:
            begin
                s_slot = wslot_reg;
                s_we   = abtk_pkg::ahead(in_rec, worst_reg);
            end
            abtk_pkg::OP_NEXT_AGE:
            begin
                age_next = age_reg + GW'(1);
            end
            abtk_pkg::OP_SCAN_FIRST:
            begin
                fill_next = fill_eff;
                slot_next = '0;
            end
            abtk_pkg::OP_CAND:
            begin
                cand_next = s_rec;
                p_next    = bcnt_reg;
                brd_next  = BW'(bcnt_reg - CW'(1));
            end
            abtk_pkg::OP_CMP:
            begin
                if (sts.ahead)
                begin
                    // The selected record moves down one place to make room.
                    b_we     = (p_reg < cnt_reg);
                    b_wdata  = brd;
                    p_next   = p_reg - CW'(1);
                    brd_next = BW'(p_reg - CW'(2));
                end
            end
            abtk_pkg::OP_PLACE:
            begin
                b_we = (p_reg < cnt_reg);
                if (bcnt_reg < cnt_reg)
                begin
                    bcnt_next = bcnt_reg + CW'(1);
                end
                if (sts.slot_last)
                begin
                    age_next = age_reg + GW'(1);
                end
                else
                begin
                    slot_next = slot_reg + SW'(1);
                end
            end
            abtk_pkg::OP_OUT_FIRST:
            begin
                brd_next = '0;
            end
            abtk_pkg::OP_OUT_NONE:
            begin
                rv_next    = 1'b1;
                found_next = 1'b0;
                oname_next = '0;
                oage_next  = '0;
                owrth_next = '0;
                last_next  = 1'b1;
            end
            abtk_pkg::OP_OUT_LOAD:
            begin
                rv_next    = 1'b1;
                found_next = 1'b1;
                oname_next = brd.name;
                oage_next  = brd.age;
                owrth_next = brd.worth;
                last_next  = sts.out_last;
                brd_next   = brd_reg + BW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fvalid_reg <= '0;
            rv_reg     <= 1'b0;
            bcnt_reg   <= '0;
            p_reg      <= '0;
            age_reg    <= '0;
            slot_reg   <= '0;
            brd_reg    <= '0;
        end
        else
        begin
            fvalid_reg <= fvalid_next;
            rv_reg     <= rv_next;
            bcnt_reg   <= bcnt_next;
            p_reg      <= p_next;
            age_reg    <= age_next;
            slot_reg   <= slot_next;
            brd_reg    <= brd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg   <= rec_next;
        worst_reg <= worst_next;
        cand_reg  <= cand_next;
        hi_reg    <= hi_next;
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        wslot_reg <= wslot_next;
        found_reg <= found_next;
        last_reg  <= last_next;
        oname_reg <= oname_next;
        oage_reg  <= oage_next;
        owrth_reg <= owrth_next;
    end

    assign rsp_valid = rv_reg;
    assign found     = found_reg;
    assign out_name  = oname_reg;
    assign out_age   = oage_reg;
    assign out_worth = owrth_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/age_bucketed_top_k_ranker_unit.sv =====
// Top level of the age-bucketed top-k ranker: joins the controller and the datapath.
// Depends on abtk_pkg, abtk_ctrl, abtk_dp and abtk_ram.
//
// The unit handles one item at a time. An insert appends to its bucket while the bucket
// has room; once the bucket is full the worst record is found by reading the bucket
// one entry a cycle. A query visits each bucket in its age range and compares each stored
// record against the selected records from the bottom of the ranked list upwards,
// stopping at the top of the list or at the first selected record it does not rank ahead of,
// the insertion into the ranked list running through one read and one write port of the
// list memory; its results then leave at one per cycle from an output register while the
// receiver takes them. The next item is taken once the last result is loaded, even while
// it still waits. After reset every bucket is empty at once.
module age_bucketed_top_k_ranker_unit #(
    parameter int BUCKET_DEPTH = 64,
    parameter int AGE_BUCKETS  = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                cmd,
    input  logic [abtk_pkg::NAME_W-1:0]         person_name,
    input  logic [abtk_pkg::AGE_W-1:0]          person_age,
    input  logic signed [abtk_pkg::WORTH_W-1:0] person_worth,
    input  logic [abtk_pkg::CNT_W-1:0]          want_count,
    input  logic [abtk_pkg::AGE_W-1:0]          age_low,
    input  logic [abtk_pkg::AGE_W-1:0]          age_high,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic                                found,
    output logic [abtk_pkg::NAME_W-1:0]         out_name,
    output logic [abtk_pkg::AGE_W-1:0]          out_age,
    output logic signed [abtk_pkg::WORTH_W-1:0] out_worth,
    output logic                                last
);

    abtk_pkg::dp_cmd_t ctl;
    abtk_pkg::dp_sts_t sts;

    abtk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    abtk_dp #(
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .AGE_BUCKETS  (AGE_BUCKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .cmd          (cmd),
        .person_name  (person_name),
        .person_age   (person_age),
        .person_worth (person_worth),
        .want_count   (want_count),
        .age_low      (age_low),
        .age_high     (age_high),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .found        (found),
        .out_name     (out_name),
        .out_age      (out_age),
        .out_worth    (out_worth),
        .last         (last)
    );

endmodule
